@@ sv/stack_allocator_engine_defines.svh @@
// Assertion macros used by the checker file of the stack allocator engine.
// Every macro expects signals named clk and arst_n in the scope where it is used.
`ifndef STACK_ALLOCATOR_ENGINE_DEFINES_SVH
`define STACK_ALLOCATOR_ENGINE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SAE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SAE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/sae_pkg.sv @@
// Package for the stack allocator engine: widths, codes and the sequencer state type.
// No dependencies; used by the top level and by its checker.
package sae_pkg;

	localparam int ADDR_W       = 32;
	localparam int SIZE_W       = 25;
	localparam int ALOG_W       = 4;
	localparam int MODE_W       = 2;
	localparam int INFO_SIZE    = 8;
	localparam int INFO_ALIGN   = 8;
	localparam int RECORD_DEPTH = 256;
	localparam int REC_IDX_W    = $clog2(RECORD_DEPTH);
	localparam int REC_CNT_W    = $clog2(RECORD_DEPTH + 1);
	localparam int ADD_W        = ADDR_W + 3;
	localparam int BUF_RESET    = 65536;

	localparam int CFG_INDEX_W  = 2;
	localparam int CFG_DATA_W   = 32;
	localparam int S_TDATA_W    = 64;
	localparam int M_TDATA_W    = 32;

	typedef enum logic [MODE_W-1:0] {
		MODE_ALIGNED = 2'd0,
		MODE_TIGHT   = 2'd1,
		MODE_FREE    = 2'd2,
		MODE_QUERY   = 2'd3
	} mode_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_BASE_ADDRESS = 2'd0,
		CFG_BUFFER_BYTES = 2'd1
	} cfg_index_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_ALIGN,
		ST_SIZE,
		ST_ROUND,
		ST_INFO,
		ST_USED,
		ST_FIT,
		ST_RD,
		ST_POP,
		ST_QUERY,
		ST_DONE
	} state_t;

endpackage

@@ sv/stack_allocator_engine.sv @@
// Stack allocator engine: a sequencer around one shared adder, a record memory
// and an output register. Depends on sae_pkg.
//
// Requests arrive on the s_axis channel; tuser carries the mode and tdata the
// size, alignment and query address. One result per request leaves on m_axis:
// tdata is the block address and tuser the success flag. Registers are written
// through the cfg channel, which is always ready; write them only while idle.
// An allocate takes several passes through the shared adder, one step per cycle:
// start, align (aligned mode only), size, round, info, used and fit. A free waits
// for the registered read of the top record and then pops it, unless no record is
// live. The next request is taken in the cycle after the result is loaded into the
// output register, even while that result still waits for the receiver; a stalled
// receiver holds the next finished result in the sequencer until the output
// register empties.
// Reset empties the record stack, clears the top offset, sets the buffer base
// to zero and its size to 65536 bytes, and drops any pending result. The record
// memory is not cleared; only entries pushed since reset are read.
module stack_allocator_engine
	import sae_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// size_bytes [24:0], align_log2 [28:25], query_address [60:29], zero [63:61]
	input  logic [S_TDATA_W-1:0]   s_axis_tdata,
	// mode [1:0]
	input  logic [MODE_W-1:0]      s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// block_address [31:0]
	output logic [M_TDATA_W-1:0]   m_axis_tdata,
	// success [0]
	output logic                   m_axis_tuser,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	state_t state_q, state_d;

	logic [ADDR_W-1:0]    base_q;
	logic [SIZE_W-1:0]    buf_q;
	logic [SIZE_W-1:0]    top_q;
	logic [REC_CNT_W-1:0] count_q;

	mode_t                mode_q;
	logic [SIZE_W-1:0]    size_q;
	logic [ALOG_W-1:0]    alog_q;
	logic [ADDR_W-1:0]    query_q;
	logic [ADD_W-1:0]     acc_q;
	logic [ADD_W-1:0]     start_q;
	logic [ADD_W-1:0]     blk_q;
	logic [ADD_W-1:0]     used_q;
	logic [ADDR_W-1:0]    res_addr_q;
	logic                 res_ok_q;

	logic                 out_valid_q;
	logic [ADDR_W-1:0]    out_addr_q;
	logic                 out_ok_q;

	logic [SIZE_W-1:0]    rec_mem [RECORD_DEPTH];
	logic [SIZE_W-1:0]    rd_data_q;
	logic [REC_IDX_W-1:0] rd_addr;
	logic [REC_IDX_W-1:0] wr_addr;
	logic [REC_CNT_W-1:0] count_dec;
	logic                 mem_we;

	logic [ADD_W-1:0]     add_a;
	logic [ADD_W-1:0]     add_b;
	logic                 add_sub;
	logic [ADD_W-1:0]     add_sum;
	logic [ADD_W-1:0]     round_mask;
	logic [ADD_W-1:0]     align_mask;
	logic [ADD_W-1:0]     info_mask;
	logic [ADD_W-1:0]     end_limit;

	logic                 in_xfer;
	logic                 out_free;
	logic                 fit;
	logic                 query_ok;
	logic                 pop_borrow;

	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_addr_q;
	assign m_axis_tuser  = out_ok_q;

	assign align_mask = ~({ADD_W{1'b1}} << alog_q);
	assign info_mask  = (mode_q == MODE_ALIGNED) ? ADD_W'(INFO_ALIGN - 1) : '0;
	assign end_limit  = ADD_W'(1) << ADDR_W;

	// The single adder of the datapath; its operands follow the sequencer step.
	assign add_sum = add_a + (add_sub ? ~add_b : add_b) + ADD_W'(add_sub);

	assign fit = (add_sum <= ADD_W'(buf_q)) && (count_q < REC_CNT_W'(RECORD_DEPTH)) &&
		(acc_q <= end_limit);
	assign query_ok   = (ADD_W'(query_q) < add_sum) && (query_q >= base_q);
	assign pop_borrow = add_sum[ADD_W-1];

	assign count_dec = count_q - REC_CNT_W'(1);
	assign rd_addr   = count_dec[REC_IDX_W-1:0];
	assign wr_addr   = count_q[REC_IDX_W-1:0];
	assign mem_we    = (state_q == ST_FIT) && fit;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					unique case (mode_t'(s_axis_tuser))
						MODE_ALIGNED, MODE_TIGHT: state_d = ST_START;
						MODE_FREE:                state_d = (count_q == '0) ? ST_DONE : ST_RD;
						MODE_QUERY:               state_d = ST_QUERY;
						default:                  state_d = ST_DONE;
					endcase
				end
			end
			ST_START: state_d = (mode_q == MODE_ALIGNED) ? ST_ALIGN : ST_SIZE;
			ST_ALIGN: state_d = ST_SIZE;
			ST_SIZE:  state_d = ST_ROUND;
			ST_ROUND: state_d = ST_INFO;
			ST_INFO:  state_d = ST_USED;
			ST_USED:  state_d = ST_FIT;
			ST_FIT:   state_d = ST_DONE;
			ST_RD:    state_d = ST_POP;
			ST_POP:   state_d = ST_DONE;
			ST_QUERY: state_d = ST_DONE;
			ST_DONE:  state_d = out_free ? ST_IDLE : ST_DONE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		add_a      = '0;
		add_b      = '0;
		add_sub    = 1'b0;
		round_mask = '0;
		unique case (state_q)
			ST_START: begin
				add_a = ADD_W'(base_q);
				add_b = ADD_W'(top_q);
			end
			ST_ALIGN: begin
				add_a      = acc_q;
				add_b      = align_mask;
				round_mask = align_mask;
			end
			ST_SIZE: begin
				add_a = acc_q;
				add_b = ADD_W'(size_q);
			end
			ST_ROUND: begin
				add_a      = acc_q;
				add_b      = info_mask;
				round_mask = info_mask;
			end
			ST_INFO: begin
				add_a = acc_q;
				add_b = ADD_W'(INFO_SIZE);
			end
			ST_USED: begin
				add_a   = acc_q;
				add_b   = start_q;
				add_sub = 1'b1;
			end
			ST_FIT: begin
				add_a = ADD_W'(top_q);
				add_b = used_q;
			end
			ST_POP: begin
				add_a   = ADD_W'(top_q);
				add_b   = ADD_W'(rd_data_q);
				add_sub = 1'b1;
			end
			ST_QUERY: begin
				add_a = ADD_W'(base_q);
				add_b = ADD_W'(buf_q);
			end
			default: begin
				add_a = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			base_q      <= '0;
			buf_q       <= SIZE_W'(BUF_RESET);
			top_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index_t'(cfg_index))
					CFG_BASE_ADDRESS: base_q <= cfg_data[ADDR_W-1:0];
					CFG_BUFFER_BYTES: buf_q  <= cfg_data[SIZE_W-1:0];
					default:          buf_q  <= buf_q;
				endcase
			end
			if (state_q == ST_FIT && fit) begin
				top_q   <= add_sum[SIZE_W-1:0];
				count_q <= count_q + REC_CNT_W'(1);
			end
			if (state_q == ST_POP) begin
				top_q   <= pop_borrow ? '0 : add_sum[SIZE_W-1:0];
				count_q <= count_dec;
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			mode_q     <= mode_t'(s_axis_tuser);
			size_q     <= s_axis_tdata[SIZE_W-1:0];
			alog_q     <= s_axis_tdata[SIZE_W+ALOG_W-1:SIZE_W];
			query_q    <= s_axis_tdata[SIZE_W+ALOG_W+ADDR_W-1:SIZE_W+ALOG_W];
			res_addr_q <= '0;
			res_ok_q   <= 1'b0;
		end
		unique case (state_q)
			ST_START: begin
				acc_q   <= add_sum;
				start_q <= add_sum;
				blk_q   <= add_sum;
			end
			ST_ALIGN: begin
				acc_q <= add_sum & ~round_mask;
				blk_q <= add_sum & ~round_mask;
			end
			ST_SIZE, ST_INFO: begin
				acc_q <= add_sum;
			end
			ST_ROUND: begin
				acc_q <= add_sum & ~round_mask;
			end
			ST_USED: begin
				used_q <= add_sum;
			end
			ST_FIT: begin
				res_ok_q   <= fit;
				res_addr_q <= fit ? blk_q[ADDR_W-1:0] : '0;
			end
			ST_POP: begin
				res_ok_q <= 1'b1;
			end
			ST_QUERY: begin
				res_ok_q <= query_ok;
			end
			default: ;
		endcase
		if (state_q == ST_DONE && out_free) begin
			out_addr_q <= res_addr_q;
			out_ok_q   <= res_ok_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			rec_mem[wr_addr] <= used_q[SIZE_W-1:0];
		end
		rd_data_q <= rec_mem[rd_addr];
	end

endmodule

@@ sv/sae_checker.sv @@
// Port-level checker for the stack allocator engine, bound to the top level.
// Depends on sae_pkg and on stack_allocator_engine_defines.svh.
`include "stack_allocator_engine_defines.svh"

module sae_checker
	import sae_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	// size_bytes [24:0], align_log2 [28:25], query_address [60:29], zero [63:61]
	input logic [S_TDATA_W-1:0]   s_axis_tdata,
	// mode [1:0]
	input logic [MODE_W-1:0]      s_axis_tuser,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	// block_address [31:0]
	input logic [M_TDATA_W-1:0]   m_axis_tdata,
	// success [0]
	input logic                   m_axis_tuser,
	input logic                   cfg_valid,
	input logic                   cfg_ready,
	input logic [CFG_INDEX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0]  cfg_data
);

	// A stalled result keeps its payload.
	`SAE_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

	// A failed result carries a zero address.
	`SAE_ASSERT_NOW(a_fail_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0, "failed result with nonzero address")

	// The engine works on one request at a time.
	`SAE_ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request taken while busy")

	// Ready drops only after a request transfer.
	`SAE_ASSERT_NOW(a_ready_drop, $fell(s_axis_tready), $past(s_axis_tvalid), "ready dropped without a transfer")

endmodule

bind stack_allocator_engine sae_checker u_sae_checker (.*);
